// ===== sv/qat_pkg.sv =====
// Shared types and constants for the quoted argument tokenizer.
`timescale 1ns / 1ps

package qat_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] ARG_MAX  = 8'hFF;

    typedef enum logic [2:0] {
        K_CHAR    = 3'd0,
        K_NEWARG  = 3'd1,
        K_DONE    = 3'd2,
        K_NOQUOTE = 3'd3,
        K_STRAY   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_out;
        logic [7:0] arg_index;
        logic       last;
    } t_result;

    // Results of one committed item: count (0..2) and the two slots.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== sv/qat_in_if.sv =====
// Input byte channel of the tokenizer.
`timescale 1ns / 1ps

interface qat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// ===== sv/qat_out_if.sv =====
// Result channel of the tokenizer.
`timescale 1ns / 1ps

interface qat_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] byte_out;
    logic [7:0] arg_index;
    logic       last;

    modport source (output valid, output kind, output byte_out, output arg_index,
                    output last, input ready);
    modport sink   (input valid, input kind, input byte_out, input arg_index,
                    input last, output ready);
endinterface

// ===== sv/quoted_argument_tokenizer_top.sv =====
// Top level of the quoted argument tokenizer.
//
// Usage:
//   i_in  : one command-line byte per item (ch); a zero byte ends the line.
//   o_out : result items (kind, byte_out, arg_index, last). kind 0 appends
//           byte_out to the current argument, 1 opens a new argument, 2 ends
//           the line (arg_index = count - 1), 3 missing quote, 4 stray
//           backslash. last marks the final result caused by one input byte.
//   A byte causes zero, one or two results.
// Path: an accepted byte is held in the input register, its results are then
//   written into the result queue, and o_out shows the head of that queue.
// Throughput: one byte per cycle while bytes cause at most one result each
//   and o_out.ready is high; the output sends one result per cycle, so the
//   second result of a two-result byte waits in the four-entry result queue.
// Reset: the queue empties and parsing restarts outside quotes at argument 0.
// Output stall: results wait in the queue; once it cannot take two more the
//   input register holds and i_in.ready drops, without losing any item.
`timescale 1ns / 1ps

module quoted_argument_tokenizer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qat_in_if.sink    i_in,
    qat_out_if.source o_out
);

    qat_pkg::t_push push;
    logic           room;

    qat_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    qat_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_push_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n != 2'd3)
        else $error("push count out of range");

    a_pair_is_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n == 2'd2 |-> (push.r0.kind == qat_pkg::K_NEWARG) && !push.r0.last
                           && push.r1.last && (push.r1.kind == qat_pkg::K_CHAR))
        else $error("two-result item is not boundary plus byte");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n == 2'd1 |-> push.r0.last)
        else $error("single result not marked last");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !room |-> push.n == 2'd0)
        else $error("results pushed without queue room");
`endif

endmodule

// ===== sv/qat_core.sv =====
// Input register, parse state and the per-byte step logic.
`timescale 1ns / 1ps

module qat_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qat_in_if.sink        i_in,
    input  logic          i_room,
    output qat_pkg::t_push o_push
);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_ESC    = 3'd1,
        M_QUOTE  = 3'd2,
        M_QESC   = 3'd3,
        M_WS     = 3'd4
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_arg, n_arg;
    logic       r_v;
    logic [7:0] r_ch;

    logic            commit;
    logic            is_ws;
    logic [7:0]      arg_new;
    logic [1:0]      cnt;
    qat_pkg::t_result res0, res1;

    assign commit     = r_v && i_room;
    assign i_in.ready = !r_v || i_room;
    assign is_ws      = (r_ch == qat_pkg::CH_SPACE) || (r_ch == qat_pkg::CH_TAB);
    assign arg_new    = (r_arg == qat_pkg::ARG_MAX) ? r_arg : r_arg + 8'd1;

    always_comb begin
        n_mode = r_mode;
        n_arg  = r_arg;
        cnt    = 2'd0;
        res0   = '{kind: qat_pkg::K_CHAR, byte_out: 8'd0, arg_index: r_arg, last: 1'b0};
        res1   = res0;
        unique case (r_mode)
            M_ESC: begin
                cnt = 2'd1;
                if (r_ch == qat_pkg::CH_NUL) begin
                    res0.kind = qat_pkg::K_STRAY;
                    n_mode    = M_NORMAL;
                    n_arg     = 8'd0;
                end else begin
                    res0.byte_out = r_ch;
                    n_mode        = M_NORMAL;
                end
            end
            M_QUOTE, M_QESC: begin
                if (r_ch == qat_pkg::CH_NUL) begin
                    cnt       = 2'd1;
                    res0.kind = qat_pkg::K_NOQUOTE;
                    n_mode    = M_NORMAL;
                    n_arg     = 8'd0;
                end else if (r_mode == M_QESC) begin
                    cnt           = 2'd1;
                    res0.byte_out = r_ch;
                    n_mode        = M_QUOTE;
                end else if (r_ch == qat_pkg::CH_QUOTE) begin
                    n_mode = M_NORMAL;
                end else if (r_ch == qat_pkg::CH_BSL) begin
                    n_mode = M_QESC;
                end else begin
                    cnt           = 2'd1;
                    res0.byte_out = r_ch;
                end
            end
            default: begin
                // normal or whitespace run
                if (r_ch == qat_pkg::CH_NUL) begin
                    cnt       = 2'd1;
                    res0.kind = qat_pkg::K_DONE;
                    n_mode    = M_NORMAL;
                    n_arg     = 8'd0;
                end else if (is_ws) begin
                    n_mode = M_WS;
                end else begin
                    if (r_mode == M_WS) begin
                        // boundary result first, the byte (if any) lands in slot 1
                        n_arg          = arg_new;
                        cnt            = 2'd1;
                        res0.kind      = qat_pkg::K_NEWARG;
                        res0.arg_index = arg_new;
                        res1.arg_index = arg_new;
                    end
                    if (r_ch == qat_pkg::CH_QUOTE) begin
                        n_mode = M_QUOTE;
                    end else if (r_ch == qat_pkg::CH_BSL) begin
                        n_mode = M_ESC;
                    end else begin
                        n_mode = M_NORMAL;
                        if (r_mode == M_WS) begin
                            res1.byte_out = r_ch;
                        end else begin
                            res0.byte_out = r_ch;
                        end
                        cnt = cnt + 2'd1;
                    end
                end
            end
        endcase
        if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_comb begin
        o_push.n  = commit ? cnt : 2'd0;
        o_push.r0 = res0;
        o_push.r1 = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_mode <= M_NORMAL;
            r_arg  <= 8'd0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_v <= 1'b1;
            end else if (commit) begin
                r_v <= 1'b0;
            end
            if (commit) begin
                r_mode <= n_mode;
                r_arg  <= n_arg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch <= i_in.ch;
        end
    end

endmodule

// ===== sv/qat_obuf.sv =====
// Four-entry result queue: takes up to two results a cycle, sends one.
`timescale 1ns / 1ps

module qat_obuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qat_pkg::t_push i_push,
    output logic          o_room,
    qat_out_if.source     o_out
);

    qat_pkg::t_result r_mem [4];
    logic [1:0]       r_wr_ptr;
    logic [1:0]       r_rd_ptr;
    logic [2:0]       r_count;
    logic             pop;
    logic [2:0]       left;

    assign pop   = o_out.valid && o_out.ready;
    assign left  = r_count - {2'b00, pop};
    assign o_room = (left <= 3'd2);

    assign o_out.valid     = (r_count != 3'd0);
    assign o_out.kind      = r_mem[r_rd_ptr].kind;
    assign o_out.byte_out  = r_mem[r_rd_ptr].byte_out;
    assign o_out.arg_index = r_mem[r_rd_ptr].arg_index;
    assign o_out.last      = r_mem[r_rd_ptr].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push.n;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= left + {1'b0, i_push.n};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.r1;
        end
    end

endmodule
